/* design/cab_pkg.sv */
// ----------------------------------------------------------------------------
// Coverage alpha blend package
// Shared widths, the pipeline sideband word and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package cab_pkg;

  // Width of one color channel or alpha value.
  localparam int ChanW  = 8;
  // Width of one ARGB8888 pixel.
  localparam int PixW   = 4 * ChanW;
  // Width of a weight or of the normalizer N (at most 255 * 255).
  localparam int WgtW   = 2 * ChanW;
  // Width of a channel numerator M (at most 255 * 255 * 255).
  localparam int NumW   = ChanW + WgtW;
  // Divider dividend 2M + N and divisor 2N.
  localparam int DivndW = NumW + 1;
  localparam int DivsrW = WgtW + 1;
  // One quotient bit is produced per divider stage.
  localparam int QuotW  = ChanW;

  // Full alpha code.
  localparam logic [ChanW-1:0] AlphaFull = 8'hFF;

  // Sideband that travels next to the channel dividers.
  typedef struct packed {
    logic             bypass;  // pixel is final, no division result used
    logic             wr_en;   // pixel is modified
    logic [PixW-1:0]  pixel;   // final pixel when bypass is set
    logic [ChanW-1:0] alpha;   // output alpha of a partial blend
  } cab_side_t;

  // Exact x / 255, truncating, for every x below 65280 (t is WgtW bits wide).
  function automatic logic [ChanW-1:0] div255(input logic [WgtW-1:0] x);
    logic [WgtW-1:0] t;
    t = x + (x >> ChanW) + WgtW'(1);
    return t[WgtW-1:ChanW];
  endfunction

endpackage

/* design/cab_front.sv */
// ----------------------------------------------------------------------------
// Coverage alpha blend front end
// Five register stages: effective alpha, blend weights, channel numerators
// and the divider operands, with the bypass cases resolved on the side.
// ----------------------------------------------------------------------------
module cab_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [cab_pkg::PixW-1:0]      dest_pixel_i,
  input  logic [cab_pkg::PixW-1:0]      source_color_i,
  input  logic [cab_pkg::ChanW-1:0]     coverage_i,
  output logic                          valid_o,
  output cab_pkg::cab_side_t            side_o,
  output logic [3*cab_pkg::DivndW-1:0]  dividend_o,
  output logic [cab_pkg::DivsrW-1:0]    divisor_o
);

  localparam int ChanW = cab_pkg::ChanW;
  localparam int PixW  = cab_pkg::PixW;
  localparam int WgtW  = cab_pkg::WgtW;
  localparam int NumW  = cab_pkg::NumW;
  localparam int DivndW = cab_pkg::DivndW;

  // Stage A: coverage times source alpha.
  logic            vld_a_q;
  logic [PixW-1:0] dst_a_q, src_a_q;
  logic [WgtW-1:0] prod_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_a_q  <= dest_pixel_i;
    src_a_q  <= source_color_i;
    prod_a_q <= WgtW'(coverage_i) * WgtW'(source_color_i[PixW-1 -: ChanW]);
  end

  // Stage B: effective alpha, truncated division by 255.
  logic             vld_b_q;
  logic [PixW-1:0]  dst_b_q, src_b_q;
  logic [ChanW-1:0] ea_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_b_q <= dst_a_q;
    src_b_q <= src_a_q;
    ea_b_q  <= cab_pkg::div255(prod_a_q);
  end

  // Stage C: source weight ea*255 and destination weight A_dst*(255-ea).
  logic            vld_c_q;
  logic            zero_c_q, full_c_q;
  logic [PixW-1:0] dst_c_q, src_c_q;
  logic [WgtW-1:0] w1_c_q, w2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_c_q  <= dst_b_q;
    src_c_q  <= src_b_q;
    zero_c_q <= (ea_b_q == '0);
    full_c_q <= (ea_b_q == cab_pkg::AlphaFull);
    w1_c_q   <= {ea_b_q, {ChanW{1'b0}}} - WgtW'(ea_b_q);
    w2_c_q   <= WgtW'(dst_b_q[PixW-1 -: ChanW]) * WgtW'(cab_pkg::AlphaFull - ea_b_q);
  end

  // Stage D: normalizer N and the six weighted channel products.
  logic            vld_d_q;
  logic            zero_d_q, full_d_q;
  logic [PixW-1:0] dst_d_q, src_d_q;
  logic [WgtW-1:0] n_d_q;
  logic [NumW-1:0] ps_d_q [3];
  logic [NumW-1:0] pd_d_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_d_q  <= dst_c_q;
    src_d_q  <= src_c_q;
    zero_d_q <= zero_c_q;
    full_d_q <= full_c_q;
    n_d_q    <= w1_c_q + w2_c_q;
    for (int c = 0; c < 3; c++) begin
      ps_d_q[c] <= NumW'(src_c_q[c*ChanW +: ChanW]) * NumW'(w1_c_q);
      pd_d_q[c] <= NumW'(dst_c_q[c*ChanW +: ChanW]) * NumW'(w2_c_q);
    end
  end

  // Stage E: divider operands, output alpha and the bypass word.
  cab_pkg::cab_side_t side_d;
  logic               vld_e_q;
  cab_pkg::cab_side_t side_e_q;
  logic [3*DivndW-1:0] dvnd_e_q;
  logic [cab_pkg::DivsrW-1:0] dvsr_e_q;

  always_comb begin
    side_d.bypass = zero_d_q | full_d_q;
    side_d.wr_en  = !zero_d_q;
    side_d.pixel  = zero_d_q ? dst_d_q : {cab_pkg::AlphaFull, src_d_q[PixW-ChanW-1:0]};
    side_d.alpha  = cab_pkg::div255(n_d_q + WgtW'(127));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_e_q <= side_d;
    dvsr_e_q <= {n_d_q, 1'b0};
    for (int c = 0; c < 3; c++) begin
      dvnd_e_q[c*DivndW +: DivndW] <=
        {NumW'(ps_d_q[c] + pd_d_q[c]), 1'b0} + DivndW'(n_d_q);
    end
  end

  assign valid_o    = vld_e_q;
  assign side_o     = side_e_q;
  assign dividend_o = dvnd_e_q;
  assign divisor_o  = dvsr_e_q;

endmodule

/* design/cab_divider.sv */
// ----------------------------------------------------------------------------
// Coverage alpha blend channel divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cab_divider (
  input  logic                        clk_i,
  input  logic [cab_pkg::DivndW-1:0]  dividend_i,
  input  logic [cab_pkg::DivsrW-1:0]  divisor_i,
  output logic [cab_pkg::QuotW-1:0]   quotient_o
);

  localparam int DivndW = cab_pkg::DivndW;
  localparam int DivsrW = cab_pkg::DivsrW;
  localparam int QuotW  = cab_pkg::QuotW;

  logic [DivndW-1:0] rem_q  [QuotW-1];
  logic [DivsrW-1:0] dsr_q  [QuotW-1];
  logic [QuotW-1:0]  quot_q [QuotW];

  // Stage s decides quotient bit QuotW-1-s. The dividend is below 256 times
  // the divisor, so eight steps cover the whole quotient.
  for (genvar s = 0; s < QuotW; s++) begin : g_step
    localparam int Sh = QuotW - 1 - s;

    logic [DivndW-1:0] rem_in, trial;
    logic [DivsrW-1:0] dsr_in;
    logic [QuotW-1:0]  quot_in;
    logic              fits;

    // The first stage takes the operands, the others the previous stage.
    if (s == 0) begin : g_first
      assign rem_in  = dividend_i;
      assign dsr_in  = divisor_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dsr_in  = dsr_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    assign trial = DivndW'(dsr_in) << Sh;
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      quot_q[s] <= {quot_in[QuotW-2:0], fits};
    end

    // The remainder and divisor are only needed by a following stage.
    if (s < QuotW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        rem_q[s] <= fits ? (rem_in - trial) : rem_in;
        dsr_q[s] <= dsr_in;
      end
    end
  end

  assign quotient_o = quot_q[QuotW-1];

endmodule

/* design/coverage_alpha_blend.sv */
// ----------------------------------------------------------------------------
// Coverage alpha blend
// Straight-alpha source-over blend of one ARGB8888 pixel with coverage.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the five operand stages, the eight-stage channel divider
// and the output register.
// Reset clears all valid bits; words in flight at reset are dropped.
// The receiver cannot stall; each result is shown for exactly one cycle.
module coverage_alpha_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [cab_pkg::PixW-1:0]  dest_pixel_i,
  input  logic [cab_pkg::PixW-1:0]  source_color_i,
  input  logic [cab_pkg::ChanW-1:0] coverage_i,
  output logic                      valid_o,
  output logic [cab_pkg::PixW-1:0]  blended_pixel_o,
  output logic                      write_enable_o
);

  localparam int ChanW  = cab_pkg::ChanW;
  localparam int PixW   = cab_pkg::PixW;
  localparam int DivndW = cab_pkg::DivndW;
  localparam int Steps  = cab_pkg::QuotW;

  logic                       accept;
  logic                       fr_vld;
  cab_pkg::cab_side_t         fr_side;
  logic [3*DivndW-1:0]        fr_dvnd;
  logic [cab_pkg::DivsrW-1:0] fr_dvsr;
  logic [3*ChanW-1:0]         quot;

  // Every word is taken at once.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cab_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .dest_pixel_i   (dest_pixel_i),
    .source_color_i (source_color_i),
    .coverage_i     (coverage_i),
    .valid_o        (fr_vld),
    .side_o         (fr_side),
    .dividend_o     (fr_dvnd),
    .divisor_o      (fr_dvsr)
  );

  // One divider per color channel, sharing the divisor 2N.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    cab_divider u_div (
      .clk_i      (clk_i),
      .dividend_i (fr_dvnd[c*DivndW +: DivndW]),
      .divisor_i  (fr_dvsr),
      .quotient_o (quot[c*ChanW +: ChanW])
    );
  end

  // Valid bits and sideband follow the divider stages.
  logic               vld_q  [Steps];
  cab_pkg::cab_side_t side_q [Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Steps; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= fr_vld;
      for (int s = 1; s < Steps; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= fr_side;
    for (int s = 1; s < Steps; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // Output register: bypass pixel or the assembled blend.
  logic            out_vld_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_we_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_we_q  <= side_q[Steps-1].wr_en;
    out_pix_q <= side_q[Steps-1].bypass ? side_q[Steps-1].pixel
                                        : {side_q[Steps-1].alpha, quot};
  end

  assign valid_o         = out_vld_q;
  assign blended_pixel_o = out_pix_q;
  assign write_enable_o  = out_we_q;

endmodule
